// File: rtl/mlv_pkg.sv
// Shared types, constants and helper functions for the model layout validator.
// Used by mlv_cfg_regs, mlv_check and model_layout_validator_top.
package mlv_pkg;

  // Bytes taken by one section-table entry.
  localparam int unsigned EntryBytes = 32;
  // Largest table entry count whose byte size still fits in 32 bits.
  localparam logic [31:0] MaxEntries = 32'(64'hFFFF_FFFF / EntryBytes);

  localparam int unsigned InDataW  = 304;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgIdxW  = 3;

  // Reset values of the configuration registers.
  localparam logic [31:0] RstMagic     = 32'd0;
  localparam logic [15:0] RstAbiMajor  = 16'd1;
  localparam logic [31:0] RstTarget    = 32'd0;
  localparam logic [31:0] RstBaseAlign = 32'd32;
  localparam logic [31:0] RstMinBytes  = 32'd64;

  typedef enum logic [3:0] {
    ERR_OK         = 4'd0,
    ERR_MAGIC      = 4'd1,
    ERR_ABI        = 4'd2,
    ERR_TARGET     = 4'd3,
    ERR_SIZE       = 4'd4,
    ERR_COUNT      = 4'd5,
    ERR_TABLE      = 4'd6,
    ERR_TCDM       = 4'd7,
    ERR_SECTION    = 4'd8,
    ERR_RESERVED   = 4'd9,
    ERR_UNEXPECTED = 4'd10
  } err_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAGIC      = 3'd0,
    CFG_ABI_MAJOR  = 3'd1,
    CFG_TARGET     = 3'd2,
    CFG_BASE_ALIGN = 3'd3,
    CFG_MIN_BYTES  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OP_HEADER  = 1'b0,
    OP_SECTION = 1'b1
  } op_e;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] abi_major;
    logic [31:0] target;
    logic [31:0] base_align;
    logic [31:0] min_bytes;
  } cfg_t;

  // First field sits in the lowest bits of tdata, so it is listed last here.
  typedef struct packed {
    logic [31:0] sec_reserved;
    logic [31:0] sec_size;
    logic [31:0] align_value;
    logic [31:0] offset_value;
    logic [31:0] table_entries;
    logic [31:0] declared_sections;
    logic [31:0] total_bytes;
    logic [31:0] target_id;
    logic [15:0] abi_major;
    logic [31:0] magic;
  } item_t;

  typedef struct packed {
    logic        header_seen;
    logic        failed;
    logic [31:0] package_bytes;
    logic [31:0] sections_expected;
    logic [31:0] sections_checked;
    err_e        first_error;
  } state_t;

  typedef struct packed {
    err_e        error_code;
    logic [31:0] section_index;
    logic        complete;
  } result_t;

  // True only for a nonzero power-of-two alignment with the low bits of v clear.
  function automatic logic aligned_to(logic [31:0] v, logic [31:0] a);
    logic [31:0] mask;
    mask = a - 32'd1;
    return (a != 32'd0) && ((a & mask) == 32'd0) && ((v & mask) == 32'd0);
  endfunction

  function automatic logic in_range(logic [31:0] off, logic [31:0] size,
                                    logic [31:0] total);
    return (off <= total) && (size <= (total - off));
  endfunction

endpackage

// File: rtl/mlv_cfg_regs.sv
// Configuration register file of the model layout validator.
// Depends on mlv_pkg for the register index codes and reset values.
module mlv_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mlv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  output mlv_pkg::cfg_t                cfg_o
);

  mlv_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (mlv_pkg::cfg_idx_e'(cfg_index_i))
        mlv_pkg::CFG_MAGIC:      cfg_d.magic      = cfg_data_i;
        mlv_pkg::CFG_ABI_MAJOR:  cfg_d.abi_major  = cfg_data_i[15:0];
        mlv_pkg::CFG_TARGET:     cfg_d.target     = cfg_data_i;
        mlv_pkg::CFG_BASE_ALIGN: cfg_d.base_align = cfg_data_i;
        mlv_pkg::CFG_MIN_BYTES:  cfg_d.min_bytes  = cfg_data_i;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic      <= mlv_pkg::RstMagic;
      cfg_q.abi_major  <= mlv_pkg::RstAbiMajor;
      cfg_q.target     <= mlv_pkg::RstTarget;
      cfg_q.base_align <= mlv_pkg::RstBaseAlign;
      cfg_q.min_bytes  <= mlv_pkg::RstMinBytes;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/mlv_check.sv
// Combinational header and section checks plus next tracking state.
// Depends on mlv_pkg for item, state, result types and alignment helpers.
module mlv_check (
  input  mlv_pkg::cfg_t    cfg_i,
  input  mlv_pkg::state_t  state_i,
  input  mlv_pkg::op_e     op_i,
  input  mlv_pkg::item_t   item_i,
  output mlv_pkg::result_t result_o,
  output mlv_pkg::state_t  state_o
);

  mlv_pkg::err_e hdr_code;
  mlv_pkg::err_e sec_code;
  logic [31:0]   table_bytes;
  logic          sec_bad_range;
  logic [31:0]   checked_inc;

  assign table_bytes = 32'(64'(item_i.table_entries) * 64'(mlv_pkg::EntryBytes));
  assign checked_inc = state_i.sections_checked + 32'd1;

  // Header checks in file order; first failing check wins.
  always_comb begin
    priority if (item_i.magic != cfg_i.magic) begin
      hdr_code = mlv_pkg::ERR_MAGIC;
    end else if (item_i.abi_major != cfg_i.abi_major) begin
      hdr_code = mlv_pkg::ERR_ABI;
    end else if (item_i.target_id != cfg_i.target) begin
      hdr_code = mlv_pkg::ERR_TARGET;
    end else if (item_i.total_bytes < cfg_i.min_bytes ||
                 !mlv_pkg::aligned_to(item_i.total_bytes, cfg_i.base_align)) begin
      hdr_code = mlv_pkg::ERR_SIZE;
    end else if (item_i.declared_sections != item_i.table_entries) begin
      hdr_code = mlv_pkg::ERR_COUNT;
    end else if (item_i.table_entries > mlv_pkg::MaxEntries ||
                 !mlv_pkg::in_range(item_i.offset_value, table_bytes,
                                    item_i.total_bytes) ||
                 !mlv_pkg::aligned_to(item_i.offset_value, cfg_i.base_align)) begin
      hdr_code = mlv_pkg::ERR_TABLE;
    end else if (item_i.align_value != cfg_i.base_align) begin
      hdr_code = mlv_pkg::ERR_TCDM;
    end else begin
      hdr_code = mlv_pkg::ERR_OK;
    end
  end

  assign sec_bad_range =
      !mlv_pkg::aligned_to(item_i.offset_value, cfg_i.base_align) ||
      !mlv_pkg::aligned_to(item_i.sec_size, cfg_i.base_align) ||
      (item_i.align_value < cfg_i.base_align) ||
      !mlv_pkg::aligned_to(item_i.offset_value, item_i.align_value) ||
      !mlv_pkg::in_range(item_i.offset_value, item_i.sec_size, state_i.package_bytes);

  always_comb begin
    priority if (sec_bad_range) begin
      sec_code = mlv_pkg::ERR_SECTION;
    end else if (item_i.sec_reserved != 32'd0) begin
      sec_code = mlv_pkg::ERR_RESERVED;
    end else begin
      sec_code = mlv_pkg::ERR_OK;
    end
  end

  always_comb begin
    state_o                = state_i;
    result_o.error_code    = mlv_pkg::ERR_UNEXPECTED;
    result_o.section_index = state_i.sections_checked;
    result_o.complete      = 1'b1;
    priority if (op_i == mlv_pkg::OP_HEADER) begin
      // A header always restarts the model.
      state_o.header_seen       = 1'b1;
      state_o.package_bytes     = item_i.total_bytes;
      state_o.sections_expected = item_i.table_entries;
      state_o.sections_checked  = 32'd0;
      state_o.failed            = (hdr_code != mlv_pkg::ERR_OK);
      state_o.first_error       = hdr_code;
      result_o.error_code       = hdr_code;
      result_o.section_index    = 32'd0;
      result_o.complete         = (hdr_code != mlv_pkg::ERR_OK) ||
                                  (item_i.table_entries == 32'd0);
    end else if (!state_i.header_seen) begin
      result_o.error_code    = mlv_pkg::ERR_UNEXPECTED;
      result_o.section_index = 32'd0;
    end else if (state_i.failed) begin
      result_o.error_code = state_i.first_error;
    end else if (state_i.sections_checked >= state_i.sections_expected) begin
      result_o.error_code = mlv_pkg::ERR_UNEXPECTED;
    end else begin
      state_o.sections_checked = checked_inc;
      result_o.error_code      = sec_code;
      if (sec_code != mlv_pkg::ERR_OK) begin
        state_o.failed      = 1'b1;
        state_o.first_error = sec_code;
        result_o.complete   = 1'b1;
      end else begin
        result_o.complete = (checked_inc == state_i.sections_expected);
      end
    end
  end

endmodule

// File: rtl/model_layout_validator_top.sv
// Model layout validator: one status result per header or section item.
// Stages: input register, then result register; each item passes both in that order.
// Throughput: one item per cycle while m_axis_tready_i does not stall the output.
// Tracking state updates with the result register.
// Reset (rst_ni low, asynchronous): both stages empty, tracking state cleared,
// configuration registers back to their defaults.
module model_layout_validator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mlv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  // item input
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // magic, abi_major, target_id, total_bytes, declared_sections, table_entries,
  // offset_value, align_value, sec_size, sec_reserved
  input  logic [mlv_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic [0:0]                   s_axis_tuser_i,   // op
  // status output
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [mlv_pkg::OutDataW-1:0] m_axis_tdata_o,   // error_code, section_index
  output logic                         m_axis_tlast_o    // complete
);

  mlv_pkg::cfg_t    cfg;
  mlv_pkg::state_t  state_q, state_d;
  mlv_pkg::result_t chk_result;
  mlv_pkg::result_t result_q;
  mlv_pkg::item_t   item_q;
  mlv_pkg::op_e     op_q;
  logic             in_valid_q, in_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             advance;
  logic             process;
  logic             in_xfer;

  mlv_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Result register frees up when empty or drained this cycle.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign process         = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign in_valid_d  = in_xfer || (in_valid_q && !advance);
  assign out_valid_d = process || (out_valid_q && !m_axis_tready_i);

  mlv_check u_check (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .op_i     (op_q),
    .item_i   (item_q),
    .result_o (chk_result),
    .state_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (process) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= mlv_pkg::item_t'(s_axis_tdata_i);
      op_q   <= mlv_pkg::op_e'(s_axis_tuser_i[0]);
    end
    if (process) begin
      result_q <= chk_result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, result_q.section_index, result_q.error_code};
  assign m_axis_tlast_o  = result_q.complete;

  // Any error verdict closes the model.
  a_error_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && result_q.error_code != mlv_pkg::ERR_OK) |-> m_axis_tlast_o)
    else $error("error result without complete");

  // Never check more sections than the header announced.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.sections_checked <= state_q.sections_expected)
    else $error("sections_checked passed sections_expected");

  // Failure flag and latched code agree.
  a_failed_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.failed == (state_q.first_error != mlv_pkg::ERR_OK))
    else $error("failed flag and first_error disagree");

  // Full input stage behind a stalled result takes nothing new.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while pipeline is full and stalled");

endmodule
